/* hw/rtl/dmart_pkg.sv */
package dmart_pkg;

    // request opcodes
    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_REMOVE    = 2'd1;
    localparam logic [1:0] OP_TRANSLATE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // field widths
    localparam int unsigned ADDR_W = 64;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned SLOT_W = 5;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ADD,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/dma_region_translation_table_core.sv */
// Channel | Direction | Handshake                 | Word fields
// in      | input     | i_in_valid / o_in_stall   | opcode, virt_address, phys_base, region_size
// out     | output    | o_out_valid / i_out_stall | status, phys_address, virt_echo, slot_index
//
// One request at a time. The slot table sits in a memory with one registered read port,
// scanned one slot per cycle from slot 0 up; the scan stops at the first match or after
// the last slot, and a translate hit passes through the add state (S_ADD) before the result.
// An unused opcode answers without touching the table.
// Reset clears every slot valid bit at once; slot contents are read but never used while invalid.
// The input is stalled while a request is in progress; a finished result waits in
// S_DONE and holds the block there until the output register is free to take it.
module dma_region_translation_table_core
    import dmart_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [ADDR_W-1:0] i_virt_address,
    input  logic [ADDR_W-1:0] i_phys_base,
    input  logic [LEN_W-1:0]  i_region_size,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [ADDR_W-1:0] o_phys_address,
    output logic [ADDR_W-1:0] o_virt_echo,
    output logic [SLOT_W-1:0] o_slot_index
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned EXT_W = IDX_W + SLOT_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

    // slot storage
    logic [ADDR_W-1:0] mem_virt [TABLE_ENTRIES];
    logic [ADDR_W-1:0] mem_phys [TABLE_ENTRIES];
    logic [LEN_W-1:0]  mem_len  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    t_state r_state, n_state;

    // request word
    logic [1:0]        r_op;
    logic [ADDR_W-1:0] r_va;
    logic [ADDR_W-1:0] r_pb;
    logic [LEN_W-1:0]  r_len;

    // scan pipeline: issue index and registered read data
    logic [CNT_W-1:0]  r_idx;
    logic              r_rd_live;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [ADDR_W-1:0] r_rd_virt;
    logic [ADDR_W-1:0] r_rd_phys;
    logic [LEN_W-1:0]  r_rd_len;

    // translate hit hold
    logic [ADDR_W-1:0] r_off;
    logic [ADDR_W-1:0] r_hit_phys;

    // pending result
    logic [1:0]        r_res_status;
    logic [ADDR_W-1:0] r_res_pa;
    logic [SLOT_W-1:0] r_res_slot;

    // output register
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [ADDR_W-1:0] r_out_pa;
    logic [ADDR_W-1:0] r_out_va;
    logic [SLOT_W-1:0] r_out_slot;

    // control
    logic in_accept;
    logic issue;
    logic scan_end;
    logic hit;
    logic out_free;
    logic load_out;
    logic op_known;

    // shared adder
    logic [ADDR_W-1:0] add_a;
    logic [ADDR_W-1:0] add_b;
    logic              add_cin;
    logic [ADDR_W:0]   sum;

    logic              slot_ok;
    logic              off_fits;
    logic [EXT_W-1:0]  idx_ext;
    logic [SLOT_W-1:0] rd_slot;

    // shared unit: compare by subtract while scanning, final add on a translate hit
    always_comb begin
        if (r_state == S_ADD) begin
            add_a   = r_off;
            add_b   = r_hit_phys;
            add_cin = 1'b0;
        end else begin
            add_a   = r_va;
            add_b   = ~r_rd_virt;
            add_cin = 1'b1;
        end
    end
    assign sum = {1'b0, add_a} + {1'b0, add_b} + {{ADDR_W{1'b0}}, add_cin};

    // slot match check on the word read last cycle
    assign slot_ok  = r_valid[r_rd_idx];
    assign off_fits = (sum[ADDR_W-1:LEN_W] == '0) && (sum[LEN_W-1:0] < r_rd_len);
    assign idx_ext  = EXT_W'(r_rd_idx);
    assign rd_slot  = idx_ext[SLOT_W-1:0];

    always_comb begin
        case (r_op)
            OP_INSERT:    hit = r_rd_live && !slot_ok;
            OP_REMOVE:    hit = r_rd_live && slot_ok && (sum[ADDR_W-1:0] == '0);
            OP_TRANSLATE: hit = r_rd_live && slot_ok && sum[ADDR_W] && off_fits;
            default:      hit = 1'b0;
        endcase
    end

    assign scan_end = !r_rd_live && (r_idx == LAST_CNT);
    assign op_known = i_opcode inside {OP_INSERT, OP_REMOVE, OP_TRANSLATE};
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = op_known ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (hit) n_state = (r_op == OP_TRANSLATE) ? S_ADD : S_DONE;
                else if (scan_end) n_state = S_DONE;
            end
            S_ADD:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_accept = 1'b0;
        issue     = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE:  in_accept = i_in_valid;
            S_SCAN:  issue     = (r_idx < LAST_CNT);
            S_DONE:  load_out  = out_free;
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // memory read and insert write
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_virt <= mem_virt[r_idx[IDX_W-1:0]];
            r_rd_phys <= mem_phys[r_idx[IDX_W-1:0]];
            r_rd_len  <= mem_len[r_idx[IDX_W-1:0]];
            r_rd_idx  <= r_idx[IDX_W-1:0];
        end
        if (r_state == S_SCAN && hit && r_op == OP_INSERT) begin
            mem_virt[r_rd_idx] <= r_va;
            mem_phys[r_rd_idx] <= r_pb;
            mem_len[r_rd_idx]  <= r_len;
        end
    end

    // scan counter and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rd_live <= 1'b0;
            r_valid   <= '0;
        end else begin
            if (in_accept) begin
                r_idx     <= '0;
                r_rd_live <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_rd_live <= issue;
                if (issue) r_idx <= r_idx + 1'b1;
            end else begin
                r_rd_live <= 1'b0;
            end
            if (r_state == S_SCAN && hit) begin
                if (r_op == OP_INSERT)      r_valid[r_rd_idx] <= 1'b1;
                else if (r_op == OP_REMOVE) r_valid[r_rd_idx] <= 1'b0;
            end
        end
    end

    // request capture and result build
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op         <= i_opcode;
            r_va         <= i_virt_address;
            r_pb         <= i_phys_base;
            r_len        <= i_region_size;
            r_res_status <= ST_MISS;
            r_res_pa     <= '0;
            r_res_slot   <= '0;
        end else if (r_state == S_SCAN) begin
            if (hit) begin
                r_res_slot <= rd_slot;
                case (r_op)
                    OP_INSERT: begin
                        r_res_status <= ST_OK;
                        r_res_pa     <= r_pb;
                    end
                    OP_REMOVE:    r_res_status <= ST_OK;
                    OP_TRANSLATE: begin
                        r_off      <= sum[ADDR_W-1:0];
                        r_hit_phys <= r_rd_phys;
                    end
                    default: ;
                endcase
            end else if (scan_end) begin
                r_res_status <= (r_op == OP_INSERT) ? ST_FULL : ST_MISS;
            end
        end else if (r_state == S_ADD) begin
            r_res_status <= ST_OK;
            r_res_pa     <= sum[ADDR_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_pa     <= r_res_pa;
            r_out_va     <= r_va;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_phys_address = r_out_pa;
    assign o_virt_echo    = r_out_va;
    assign o_slot_index   = r_out_slot;

    // checks
    a_insert_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && hit && r_op == OP_INSERT) |=> r_valid[$past(r_rd_idx)])
        else $error("inserted slot not marked valid");

    a_remove_clears_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && hit && r_op == OP_REMOVE) |=> !r_valid[$past(r_rd_idx)])
        else $error("removed slot still valid");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_CNT)
        else $error("scan index past table end");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_phys_address == '0 && o_slot_index == '0))
        else $error("failed request carries address or slot");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted request left the sequencer idle");

endmodule
